// File: rtl/core/tpwp_pkg.sv
package tpwp_pkg;

  // depth of the command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one classified tuning request, ready to be serialized
  typedef struct packed {
    logic       range_error;
    logic       ref_half;    // 500 kHz reference step
    logic       psc16;       // prescaler 16
    logic       div_bit;
    logic [2:0] band;
    logic [7:0] n_cnt;
    logic [4:0] a_cnt;
  } cmd_t;

  // byte positions of the write sequence
  typedef enum logic [3:0] {
    SLOT_INIT0,
    SLOT_INIT1,
    SLOT_INIT2,
    SLOT_INIT3,
    SLOT_WORD0,
    SLOT_WORD1,
    SLOT_WORD2,
    SLOT_WORD3,
    SLOT_TEST,
    SLOT_LPF2,
    SLOT_LPF3,
    SLOT_REWRITE0
  } slot_t;

endpackage

// File: rtl/core/tpwp_front.sv
module tpwp_front
  import tpwp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_take,
  input  logic [21:0] req_freq,
  output logic        cmd_valid,
  output cmd_t        cmd,
  output logic [1:0]  inflight
);

  localparam logic [21:0] F_MIN      = 22'd950000;
  localparam logic [21:0] F_MAX      = 22'd2150000;
  localparam logic [21:0] F_REF_HALF = 22'd1024000;
  localparam logic [21:0] F_PSC16    = 22'd1375000;
  localparam logic [22:0] ROUND_ADD  = 23'd500;
  // ceil(2^32 / 1000): exact floor(x / 1000) for x below 2^22
  localparam logic [22:0] RECIP_1000 = 23'd4294968;

  localparam logic [21:0] BAND_LIMIT [8] = '{
    22'd986000, 22'd1073000, 22'd1154000, 22'd1291000,
    22'd1447000, 22'd1615000, 22'd1791000, 22'd1972000
  };
  localparam logic       BAND_DIV [9] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam logic [2:0] BAND_BA  [9] = '{3'd5, 3'd6, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};

  // stage 1: captured request
  logic        s1_v_r;
  logic [21:0] s1_f_r;

  // stage 2: classification and rounded numerator
  logic        s2_v_r, s2_err_r, s2_ref_r, s2_psc_r, s2_div_r;
  logic [2:0]  s2_band_r;
  logic [22:0] s2_x_r;
  logic        s2_err_nxt, s2_ref_nxt, s2_psc_nxt, s2_div_nxt;
  logic [2:0]  s2_band_nxt;
  logic [22:0] s2_x_nxt;
  logic [3:0]  band_idx;

  // stage 3: division count
  logic        s3_v_r, s3_err_r, s3_ref_r, s3_psc_r, s3_div_r;
  logic [2:0]  s3_band_r;
  logic [11:0] s3_count_r;
  logic [45:0] prod;
  logic [11:0] s3_count_nxt;

  always_comb begin
    band_idx = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (s1_f_r <= BAND_LIMIT[i]) begin
        band_idx = i[3:0];
      end
    end
    s2_err_nxt  = (s1_f_r < F_MIN) || (s1_f_r > F_MAX);
    s2_ref_nxt  = s1_f_r < F_REF_HALF;
    s2_psc_nxt  = s1_f_r <= F_PSC16;
    s2_div_nxt  = BAND_DIV[band_idx];
    s2_band_nxt = BAND_BA[band_idx];
    // count = round(f * 1000 / step) reduces to floor(x / 1000)
    if (s2_ref_nxt) begin
      s2_x_nxt = {s1_f_r, 1'b0} + ROUND_ADD;
    end else begin
      s2_x_nxt = {1'b0, s1_f_r} + ROUND_ADD;
    end
  end

  assign prod         = s2_x_r * RECIP_1000;
  assign s3_count_nxt = prod[43:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= req_take;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_f_r <= req_freq;
    end
    s2_err_r   <= s2_err_nxt;
    s2_ref_r   <= s2_ref_nxt;
    s2_psc_r   <= s2_psc_nxt;
    s2_div_r   <= s2_div_nxt;
    s2_band_r  <= s2_band_nxt;
    s2_x_r     <= s2_x_nxt;
    s3_err_r   <= s2_err_r;
    s3_ref_r   <= s2_ref_r;
    s3_psc_r   <= s2_psc_r;
    s3_div_r   <= s2_div_r;
    s3_band_r  <= s2_band_r;
    s3_count_r <= s3_count_nxt;
  end

  // split count into N and A by the prescaler
  always_comb begin
    cmd.range_error = s3_err_r;
    cmd.ref_half    = s3_ref_r;
    cmd.psc16       = s3_psc_r;
    cmd.div_bit     = s3_div_r;
    cmd.band        = s3_band_r;
    if (s3_psc_r) begin
      cmd.n_cnt = s3_count_r[11:4];
      cmd.a_cnt = {1'b0, s3_count_r[3:0]};
    end else begin
      cmd.n_cnt = {1'b0, s3_count_r[11:5]};
      cmd.a_cnt = s3_count_r[4:0];
    end
  end

  assign cmd_valid = s3_v_r;
  assign inflight  = {1'b0, s1_v_r} + {1'b0, s2_v_r} + {1'b0, s3_v_r};

endmodule

// File: rtl/core/tpwp_cmd_fifo.sv
module tpwp_cmd_fifo
  import tpwp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  cmd_t              wr_data,
  input  logic              rd_en,
  output cmd_t              rd_data,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_rd;

  assign do_rd     = rd_en && (count_r != '0);
  assign not_empty = count_r != '0;
  assign count     = count_r;
  assign rd_data   = slot_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_en && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (!wr_en && do_rd) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_q[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/core/tpwp_back.sv
module tpwp_back
  import tpwp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head,
  input  logic [1:0] gain,
  input  logic [5:0] lpf_mhz,
  output logic       head_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] data_byte,
  output logic       starts_write,
  output logic       last_byte,
  output logic       range_error
);

  localparam logic [7:0] INIT_B0  = 8'h20;
  localparam logic [7:0] INIT_B1  = 8'h00;
  localparam logic [7:0] INIT_B2  = 8'hE0;
  localparam logic [7:0] INIT_B3  = 8'h00;
  localparam logic [7:0] TEST_BIT = 8'h04;
  localparam logic [5:0] LPF_LO   = 6'd10;
  localparam logic [5:0] LPF_HI   = 6'd34;
  localparam logic [3:0] LPF_CODE [13] = '{
    4'h3, 4'h8, 4'hA, 4'h9, 4'hB, 4'h4, 4'h6, 4'h5, 4'h7, 4'hC, 4'hE, 4'hD, 4'hF
  };

  slot_t      slot_r, slot_nxt;
  logic       out_v_r;
  logic [7:0] byte_r;
  logic       start_r, last_r, err_r;

  logic       out_free, emit, seq_end;
  logic [5:0] lpf_off;
  logic [3:0] code;
  logic [7:0] b0, b1, b2, b3, b_test, b_lpf2, b_lpf3;
  logic [7:0] byte_nxt;
  logic       start_nxt;

  assign out_free = !out_v_r || pop;
  assign emit     = head_valid && out_free;
  assign seq_end  = head.range_error || (slot_r == SLOT_REWRITE0);
  assign head_pop = emit && seq_end;

  assign lpf_off = lpf_mhz - LPF_LO;

  always_comb begin
    code = 4'h0;
    if ((lpf_mhz >= LPF_LO) && (lpf_mhz <= LPF_HI) && !lpf_mhz[0]) begin
      code = LPF_CODE[lpf_off[4:1]];
    end
  end

  // charge pump bit 1 lands on byte 2 bit 6, already set by the init value
  assign b0     = INIT_B0 | {1'b0, gain, 5'b0} | {3'b0, head.n_cnt[7:3]};
  assign b1     = {head.n_cnt[2:0], head.a_cnt};
  assign b2     = INIT_B2 | {7'b0, head.ref_half};
  assign b3     = {head.band, head.psc16, 2'b00, head.div_bit, 1'b0};
  assign b_test = b2 | TEST_BIT;
  assign b_lpf2 = b_test | {3'b0, code[1:0], 3'b0};
  assign b_lpf3 = b3 | {4'b0, code[3:2], 2'b0};

  always_comb begin
    byte_nxt  = 8'h00;
    start_nxt = 1'b0;
    unique case (slot_r)
      SLOT_INIT0:    begin byte_nxt = INIT_B0; start_nxt = 1'b1; end
      SLOT_INIT1:    byte_nxt = INIT_B1;
      SLOT_INIT2:    byte_nxt = INIT_B2;
      SLOT_INIT3:    byte_nxt = INIT_B3;
      SLOT_WORD0:    begin byte_nxt = b0; start_nxt = 1'b1; end
      SLOT_WORD1:    byte_nxt = b1;
      SLOT_WORD2:    byte_nxt = b2;
      SLOT_WORD3:    byte_nxt = b3;
      SLOT_TEST:     begin byte_nxt = b_test; start_nxt = 1'b1; end
      SLOT_LPF2:     begin byte_nxt = b_lpf2; start_nxt = 1'b1; end
      SLOT_LPF3:     byte_nxt = b_lpf3;
      SLOT_REWRITE0: begin byte_nxt = b0; start_nxt = 1'b1; end
      default:       byte_nxt = 8'h00;
    endcase
    if (head.range_error) begin
      byte_nxt  = 8'h00;
      start_nxt = 1'b0;
    end
  end

  always_comb begin
    slot_nxt = slot_r;
    if (emit) begin
      if (seq_end) begin
        slot_nxt = SLOT_INIT0;
      end else begin
        slot_nxt = slot_t'(slot_r + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= SLOT_INIT0;
      out_v_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      if (out_free) begin
        out_v_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r  <= byte_nxt;
      start_r <= start_nxt;
      last_r  <= seq_end;
      err_r   <= head.range_error;
    end
  end

  assign empty        = !out_v_r;
  assign data_byte    = byte_r;
  assign starts_write = start_r;
  assign last_byte    = last_r;
  assign range_error  = err_r;

endmodule

// File: rtl/core/tuner_pll_word_programmer.sv
// tuner pll word programmer
// input channel: a request carries a tuning frequency in kHz and is taken on a
//   clock edge with push high and full low
// result channel: one byte per result, with starts_write, last_byte and
//   range_error; the head byte is shown while empty is low and leaves on pop
// an in-range request gives 12 bytes (init, full word, test-mode set, low-pass
//   code, byte 0 rewrite); an out-of-range one gives a single error result
// the first byte passes the capture, classify and multiply stages, the queue
//   and the output register before it shows; after that one byte per cycle
//   while pop stays high; the front takes new requests before earlier ones
//   leave, as a request frees its queue credit when its last byte is registered
// a 3-stage front (capture, classify, multiply by 1/1000) feeds a 4-entry
//   command queue; full rises once queued plus in-flight requests reach 4
// when pop stays low the output byte holds, the back end stops, and the front
//   keeps taking requests until the queue credit runs out
// reset empties the pipeline and queue and sets gain to 2, cutoff to 34 MHz
// config registers (apb, byte address 0 and 4): baseband gain, lowpass cutoff;
//   they are read by the back end as each byte is formed, so write them idle
module tuner_pll_word_programmer
  import tpwp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        push,
  output logic        full,
  input  logic [21:0] in_frequency_khz,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_data_byte,
  output logic        out_starts_write,
  output logic        out_last_byte,
  output logic        out_range_error,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_LPF  = 1'b1;

  localparam logic [1:0] GAIN_RESET = 2'd2;
  localparam logic [5:0] LPF_RESET  = 6'd34;

  // config registers
  logic [1:0] gain_r;
  logic [5:0] lpf_r;
  logic       cfg_wr;

  // front to queue
  logic              req_take;
  logic              cmd_valid;
  cmd_t              cmd;
  logic [1:0]        inflight;

  // queue to back
  cmd_t              head;
  logic              head_valid;
  logic              head_pop;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   credit_used;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      lpf_r  <= LPF_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_GAIN: gain_r <= pwdata[1:0];
        REG_LPF:  lpf_r  <= pwdata[5:0];
        default:  gain_r <= gain_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GAIN: prdata = {30'b0, gain_r};
      REG_LPF:  prdata = {26'b0, lpf_r};
      default:  prdata = 32'b0;
    endcase
  end

  // every request in the front pipeline has a queue entry reserved
  assign credit_used = {1'b0, q_count} + {{(QCNT_W - 1){1'b0}}, inflight};
  assign full        = credit_used >= (QCNT_W + 1)'(QDEPTH);
  assign req_take    = push && !full;

  tpwp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_take  (req_take),
    .req_freq  (in_frequency_khz),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .inflight  (inflight)
  );

  tpwp_cmd_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cmd_valid),
    .wr_data   (cmd),
    .rd_en     (head_pop),
    .rd_data   (head),
    .not_empty (head_valid),
    .count     (q_count)
  );

  tpwp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .gain         (gain_r),
    .lpf_mhz      (lpf_r),
    .head_pop     (head_pop),
    .pop          (pop),
    .empty        (empty),
    .data_byte    (out_data_byte),
    .starts_write (out_starts_write),
    .last_byte    (out_last_byte),
    .range_error  (out_range_error)
  );

`ifndef NO_ASSERTIONS
  // queue plus front pipeline never exceed the queue depth
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= (QCNT_W + 1)'(QDEPTH))
    else $error("command queue credit overrun");

  // an error result is a lone, final, empty byte
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_range_error) |-> (out_last_byte && !out_starts_write &&
                                     out_data_byte == 8'h00))
    else $error("malformed range error result");

  // the byte 0 rewrite closing a sequence opens its own write
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_byte && !out_range_error) |-> out_starts_write)
    else $error("final byte does not start a write");

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> empty)
    else $error("result shown right after reset");
`endif

endmodule
